FILE: hw/rtl/sgb_pkg.sv
`timescale 1ns / 1ps

package sgb_pkg;

	localparam int NODE_DEPTH_DEF = 64;
	localparam int EDGE_DEPTH_DEF = 128;
	localparam int COORD_W        = 16;
	localparam int KEY_W          = 2 * COORD_W;
	localparam int IDX_W          = 6;
	localparam int NTOT_W         = 7;
	localparam int ETOT_W         = 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NODE_A,
		S_NODE_B,
		S_EDGE,
		S_RESULT
	} sgb_state_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NODE_FULL = 2'd1,
		ST_EDGE_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [COORD_W-1:0] first_x;
		logic [COORD_W-1:0] first_y;
		logic [COORD_W-1:0] second_x;
		logic [COORD_W-1:0] second_y;
		logic               final_segment;
	} seg_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  first_index;
		logic [IDX_W-1:0]  second_index;
		logic              first_added;
		logic              second_added;
		logic              edge_added;
		status_t           status;
		logic [NTOT_W-1:0] node_total;
		logic [ETOT_W-1:0] edge_total;
		logic              map_done;
	} graph_result_t;

endpackage

FILE: hw/rtl/sgb_seg_if.sv
`timescale 1ns / 1ps

interface sgb_seg_if;
	logic                valid;
	logic                ready;
	sgb_pkg::seg_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/sgb_res_if.sv
`timescale 1ns / 1ps

interface sgb_res_if;
	logic                    valid;
	logic                    ready;
	sgb_pkg::graph_result_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/sgb_ram.sv
`timescale 1ns / 1ps

module sgb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/segment_graph_builder_top.sv
`timescale 1ns / 1ps

// Each segment runs a node table scan for its first endpoint, another for its second
// endpoint and an edge table scan, then a registered result beat; a full node table
// ends the segment early. Segments are taken only in the idle state; one shared key
// comparator scans one table entry per cycle via each table's registered read port.
// Reset clears the fill counts and the sequencer; table contents need no clearing.
module segment_graph_builder_top #(
	parameter int NODE_DEPTH = sgb_pkg::NODE_DEPTH_DEF,
	parameter int EDGE_DEPTH = sgb_pkg::EDGE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sgb_seg_if.sink    seg,
	sgb_res_if.source  res
);

	localparam int NAW = $clog2(NODE_DEPTH);
	localparam int EAW = $clog2(EDGE_DEPTH);
	localparam int NCW = $clog2(NODE_DEPTH + 1);
	localparam int ECW = $clog2(EDGE_DEPTH + 1);
	localparam int PW  = (NCW > ECW) ? NCW : ECW;
	localparam int IW  = (NAW > EAW) ? NAW : EAW;
	localparam int KW  = sgb_pkg::KEY_W;

	sgb_pkg::sgb_state_t state_q, state_d;

	logic [PW-1:0]  ptr_q;
	logic           cmp_v_q;
	logic [IW-1:0]  cmp_idx_q;
	logic [NCW-1:0] node_fill_q;
	logic [ECW-1:0] edge_fill_q;
	logic           out_v_q;

	sgb_pkg::seg_item_t     item_q;
	sgb_pkg::graph_result_t out_q;
	logic [NAW-1:0]         idx_a_q, idx_b_q;
	logic                   added_a_q, added_b_q, edge_added_q;
	sgb_pkg::status_t       status_q;

	logic [KW-1:0]      node_rdata;
	logic [2*NAW-1:0]   edge_rdata;
	logic [KW-1:0]      key, rd;
	logic               scanning, hit, at_end, full, issue;
	logic               node_we, edge_we, accept, load_out;

	sgb_ram #(.WIDTH(KW), .DEPTH(NODE_DEPTH)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_fill_q[NAW-1:0]),
		.wdata (key),
		.raddr (ptr_q[NAW-1:0]),
		.rdata (node_rdata)
	);

	sgb_ram #(.WIDTH(2*NAW), .DEPTH(EDGE_DEPTH)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_fill_q[EAW-1:0]),
		.wdata ({idx_a_q, idx_b_q}),
		.raddr (ptr_q[EAW-1:0]),
		.rdata (edge_rdata)
	);

	assign accept    = seg.valid && seg.ready;
	assign seg.ready = (state_q == sgb_pkg::S_IDLE);
	assign res.valid = out_v_q;
	assign res.data  = out_q;
	assign load_out  = (state_q == sgb_pkg::S_RESULT) && (!out_v_q || res.ready);

	// shared compare unit
	always_comb begin
		if (state_q == sgb_pkg::S_EDGE) begin
			key    = KW'({idx_a_q, idx_b_q});
			rd     = KW'(edge_rdata);
			at_end = (ptr_q == PW'(edge_fill_q));
			full   = (edge_fill_q == ECW'(EDGE_DEPTH));
		end else if (state_q == sgb_pkg::S_NODE_B) begin
			key    = {item_q.second_x, item_q.second_y};
			rd     = node_rdata;
			at_end = (ptr_q == PW'(node_fill_q));
			full   = (node_fill_q == NCW'(NODE_DEPTH));
		end else begin
			key    = {item_q.first_x, item_q.first_y};
			rd     = node_rdata;
			at_end = (ptr_q == PW'(node_fill_q));
			full   = (node_fill_q == NCW'(NODE_DEPTH));
		end
		scanning = (state_q == sgb_pkg::S_NODE_A) || (state_q == sgb_pkg::S_NODE_B) ||
			(state_q == sgb_pkg::S_EDGE);
		hit     = cmp_v_q && (rd == key);
		issue   = scanning && !hit && !at_end;
		node_we = ((state_q == sgb_pkg::S_NODE_A) || (state_q == sgb_pkg::S_NODE_B)) &&
			!hit && at_end && !full;
		edge_we = (state_q == sgb_pkg::S_EDGE) && !hit && at_end && !full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sgb_pkg::S_IDLE: begin
				if (seg.valid) state_d = sgb_pkg::S_NODE_A;
			end
			sgb_pkg::S_NODE_A: begin
				if (hit) state_d = sgb_pkg::S_NODE_B;
				else if (at_end) state_d = full ? sgb_pkg::S_RESULT : sgb_pkg::S_NODE_B;
			end
			sgb_pkg::S_NODE_B: begin
				if (hit) state_d = sgb_pkg::S_EDGE;
				else if (at_end) state_d = full ? sgb_pkg::S_RESULT : sgb_pkg::S_EDGE;
			end
			sgb_pkg::S_EDGE: begin
				if (hit || at_end) state_d = sgb_pkg::S_RESULT;
			end
			sgb_pkg::S_RESULT: begin
				if (!out_v_q || res.ready) state_d = sgb_pkg::S_IDLE;
			end
			default: state_d = sgb_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			cmp_v_q     <= 1'b0;
			node_fill_q <= '0;
			edge_fill_q <= '0;
			out_v_q     <= 1'b0;
		end else begin
			if (state_d != state_q) begin
				ptr_q   <= '0;
				cmp_v_q <= 1'b0;
			end else if (scanning) begin
				if (issue) ptr_q <= ptr_q + PW'(1);
				cmp_v_q <= issue;
			end
			if (node_we) node_fill_q <= node_fill_q + NCW'(1);
			if (edge_we) edge_fill_q <= edge_fill_q + ECW'(1);
			if (load_out) out_v_q <= 1'b1;
			else if (res.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_q <= ptr_q[IW-1:0];
		if (accept) begin
			item_q       <= seg.data;
			status_q     <= sgb_pkg::ST_OK;
			added_a_q    <= 1'b0;
			added_b_q    <= 1'b0;
			edge_added_q <= 1'b0;
		end
		if (state_q == sgb_pkg::S_NODE_A) begin
			if (hit) begin
				idx_a_q <= cmp_idx_q[NAW-1:0];
			end else if (at_end && full) begin
				status_q <= sgb_pkg::ST_NODE_FULL;
			end else if (at_end) begin
				idx_a_q   <= node_fill_q[NAW-1:0];
				added_a_q <= 1'b1;
			end
		end
		if (state_q == sgb_pkg::S_NODE_B) begin
			if (hit) begin
				idx_b_q <= cmp_idx_q[NAW-1:0];
			end else if (at_end && full) begin
				status_q <= sgb_pkg::ST_NODE_FULL;
			end else if (at_end) begin
				idx_b_q   <= node_fill_q[NAW-1:0];
				added_b_q <= 1'b1;
			end
		end
		if (state_q == sgb_pkg::S_EDGE && !hit && at_end) begin
			if (full) status_q <= sgb_pkg::ST_EDGE_FULL;
			else edge_added_q <= 1'b1;
		end
		if (load_out) begin
			out_q.first_index  <= (status_q == sgb_pkg::ST_OK) ?
				sgb_pkg::IDX_W'(idx_a_q) : '0;
			out_q.second_index <= (status_q == sgb_pkg::ST_OK) ?
				sgb_pkg::IDX_W'(idx_b_q) : '0;
			out_q.first_added  <= added_a_q;
			out_q.second_added <= added_b_q;
			out_q.edge_added   <= edge_added_q;
			out_q.status       <= status_q;
			out_q.node_total   <= sgb_pkg::NTOT_W'(node_fill_q);
			out_q.edge_total   <= sgb_pkg::ETOT_W'(edge_fill_q);
			out_q.map_done     <= item_q.final_segment;
		end
	end

	a_node_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		node_fill_q <= NCW'(NODE_DEPTH))
		else $error("node fill count beyond table depth");

	a_edge_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_fill_q <= ECW'(EDGE_DEPTH))
		else $error("edge fill count beyond table depth");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(node_we && edge_we))
		else $error("node and edge tables written together");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		scanning |-> !accept)
		else $error("input beat taken during a table scan");

	a_edge_after_ok: assert property (@(posedge clk) disable iff (!arst_n)
		edge_we |-> (status_q == sgb_pkg::ST_OK))
		else $error("edge inserted after a node table failure");

endmodule

FILE: dv/graph_check_pkg.sv
`timescale 1ns / 1ps

package graph_check_pkg;

	class graph_scoreboard;
		bit [sgb_pkg::COORD_W-1:0]        node_x [sgb_pkg::NODE_DEPTH_DEF];
		bit [sgb_pkg::COORD_W-1:0]        node_y [sgb_pkg::NODE_DEPTH_DEF];
		int                               node_count;
		bit [sgb_pkg::IDX_W-1:0]          pair_from [sgb_pkg::EDGE_DEPTH_DEF];
		bit [sgb_pkg::IDX_W-1:0]          pair_to [sgb_pkg::EDGE_DEPTH_DEF];
		int                               pair_count;
		sgb_pkg::graph_result_t           pending_results [$];
		int                               errors;

		function new();
			node_count = 0;
			pair_count = 0;
			errors     = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function bit place_node(input bit [sgb_pkg::COORD_W-1:0] x,
				input bit [sgb_pkg::COORD_W-1:0] y, output int idx, output bit added);
			added = 1'b0;
			idx   = 0;
			for (int i = 0; i < node_count; i++) begin
				if (node_x[i] == x && node_y[i] == y) begin
					idx = i;
					return 1'b1;
				end
			end
			if (node_count >= sgb_pkg::NODE_DEPTH_DEF)
				return 1'b0;
			node_x[node_count] = x;
			node_y[node_count] = y;
			idx   = node_count;
			added = 1'b1;
			node_count++;
			return 1'b1;
		endfunction

		function bit place_pair(input int from_idx, input int to_idx, output bit added);
			added = 1'b0;
			for (int i = 0; i < pair_count; i++) begin
				if (pair_from[i] == from_idx && pair_to[i] == to_idx)
					return 1'b1;
			end
			if (pair_count >= sgb_pkg::EDGE_DEPTH_DEF)
				return 1'b0;
			pair_from[pair_count] = sgb_pkg::IDX_W'(from_idx);
			pair_to[pair_count]   = sgb_pkg::IDX_W'(to_idx);
			added = 1'b1;
			pair_count++;
			return 1'b1;
		endfunction

		function void note_segment(input sgb_pkg::seg_item_t seg);
			sgb_pkg::graph_result_t r;
			int                     i1;
			int                     i2;
			bit                     a1;
			bit                     a2;
			bit                     ae;
			sgb_pkg::status_t       st;
			i1 = 0;
			i2 = 0;
			a1 = 1'b0;
			a2 = 1'b0;
			ae = 1'b0;
			st = sgb_pkg::ST_OK;
			if (!place_node(seg.first_x, seg.first_y, i1, a1))
				st = sgb_pkg::ST_NODE_FULL;
			else if (!place_node(seg.second_x, seg.second_y, i2, a2))
				st = sgb_pkg::ST_NODE_FULL;
			else if (!place_pair(i1, i2, ae))
				st = sgb_pkg::ST_EDGE_FULL;
			if (st != sgb_pkg::ST_OK) begin
				i1 = 0;
				i2 = 0;
				ae = 1'b0;
			end
			r.first_index  = i1[sgb_pkg::IDX_W-1:0];
			r.second_index = i2[sgb_pkg::IDX_W-1:0];
			r.first_added  = a1;
			r.second_added = a2;
			r.edge_added   = ae;
			r.status       = st;
			r.node_total   = node_count[sgb_pkg::NTOT_W-1:0];
			r.edge_total   = pair_count[sgb_pkg::ETOT_W-1:0];
			r.map_done     = seg.final_segment;
			pending_results.push_back(r);
		endfunction

		function void compare_field(input string name, input logic [7:0] want,
				input logic [7:0] got);
			if (got !== want) begin
				$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(input sgb_pkg::graph_result_t got);
			sgb_pkg::graph_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t ns: result beat with no segment pending, expected none actual %p",
					$time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("first_index", 8'(want.first_index), 8'(got.first_index));
			compare_field("second_index", 8'(want.second_index), 8'(got.second_index));
			compare_field("first_added", 8'(want.first_added), 8'(got.first_added));
			compare_field("second_added", 8'(want.second_added), 8'(got.second_added));
			compare_field("edge_added", 8'(want.edge_added), 8'(got.edge_added));
			compare_field("status", 8'(want.status), 8'(got.status));
			compare_field("node_total", 8'(want.node_total), 8'(got.node_total));
			compare_field("edge_total", want.edge_total, got.edge_total);
			compare_field("map_done", 8'(want.map_done), 8'(got.map_done));
		endfunction
	endclass

endpackage

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int POOL_SIZE = 48;

	logic clk = 1'b0;
	logic arst_n;

	sgb_seg_if seg_ch ();
	sgb_res_if res_ch ();

	segment_graph_builder_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg_ch),
		.res    (res_ch)
	);

	graph_check_pkg::graph_scoreboard sb;
	int                               send_idle_pct  = 0;
	int                               recv_stall_pct = 0;
	int                               hold_left      = 0;
	bit [sgb_pkg::COORD_W-1:0]        pool_x [POOL_SIZE];
	bit [sgb_pkg::COORD_W-1:0]        pool_y [POOL_SIZE];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("segment_graph_builder_top regression: fail");
		$finish;
	end

	function automatic sgb_pkg::seg_item_t mk_seg(input bit [15:0] x1, input bit [15:0] y1,
			input bit [15:0] x2, input bit [15:0] y2, input bit last);
		sgb_pkg::seg_item_t s;
		s.first_x       = x1;
		s.first_y       = y1;
		s.second_x      = x2;
		s.second_y      = y2;
		s.final_segment = last;
		return s;
	endfunction

	function automatic sgb_pkg::seg_item_t make_segment();
		sgb_pkg::seg_item_t s;
		int                 pick;
		int                 k;
		int                 p1;
		int                 p2;
		pick = $urandom_range(99);
		p1   = $urandom_range(POOL_SIZE - 1);
		p2   = ($urandom_range(9) == 0) ? p1 : $urandom_range(POOL_SIZE - 1);
		if (sb.pair_count > 0 && pick < 35) begin
			k = $urandom_range(sb.pair_count - 1);
			s = mk_seg(sb.node_x[sb.pair_from[k]], sb.node_y[sb.pair_from[k]],
				sb.node_x[sb.pair_to[k]], sb.node_y[sb.pair_to[k]], 1'b0);
		end else if (pick < 75 && sb.node_count != sgb_pkg::NODE_DEPTH_DEF - 1) begin
			s = mk_seg(pool_x[p1], pool_y[p1], pool_x[p2], pool_y[p2], 1'b0);
		end else if (pick < 88 || sb.node_count == sgb_pkg::NODE_DEPTH_DEF - 1) begin
			s = mk_seg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
		end else if (pick[0]) begin
			s = mk_seg(pool_x[p1], pool_y[p1], 16'($urandom), 16'($urandom), 1'b0);
		end else begin
			s = mk_seg(16'($urandom), 16'($urandom), pool_x[p2], pool_y[p2], 1'b0);
		end
		s.final_segment = ($urandom_range(15) == 0);
		return s;
	endfunction

	task automatic send_segment(input sgb_pkg::seg_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			seg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		seg_ch.valid <= 1'b1;
		seg_ch.data  <= item;
		@(posedge clk);
		while (!seg_ch.ready)
			@(posedge clk);
		sb.note_segment(item);
	endtask

	task automatic run_phase(input int count, input int s_pct, input int r_pct);
		send_idle_pct  = s_pct;
		recv_stall_pct = r_pct;
		repeat (count)
			send_segment(make_segment());
	endtask

	// receive side: check each result beat, then pick ready for the next edge
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.data);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		seg_ch.valid <= 1'b0;
		seg_ch.data  <= '0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_x[i] = sgb_pkg::COORD_W'($urandom);
			pool_y[i] = sgb_pkg::COORD_W'($urandom);
		end
		pool_x[0] = 16'h0000;
		pool_y[0] = 16'hFFFF;
		pool_x[1] = 16'hFFFF;
		pool_y[1] = 16'h0000;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_segment(mk_seg(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
		send_segment(mk_seg(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
		send_segment(mk_seg(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0));
		send_segment(mk_seg(16'h1234, 16'h5678, 16'h1234, 16'h5678, 1'b0));
		send_segment(mk_seg(16'h1234, 16'h5678, 16'h1234, 16'h5678, 1'b1));
		send_segment(mk_seg(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0));
		send_segment(mk_seg(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));
		send_segment(mk_seg(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
		send_segment(mk_seg(16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 1'b0));
		send_segment(mk_seg(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b1));
		send_segment(mk_seg(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0));
		send_segment(mk_seg(16'h0000, 16'h0001, 16'h0001, 16'h0000, 1'b0));
		send_segment(mk_seg(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0));
		send_segment(mk_seg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));

		// hold off the receiver so the block backs up onto its input
		hold_left = 3000;
		run_phase(275, 0, 0);
		run_phase(275, 67, 0);
		run_phase(275, 0, 67);
		run_phase(275, 19, 19);

		seg_ch.valid <= 1'b0;
		recv_stall_pct = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("segment_graph_builder_top regression: pass");
		end else begin
			$display("segment_graph_builder_top regression: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/sgb_pkg.sv
hw/rtl/sgb_seg_if.sv
hw/rtl/sgb_res_if.sv
hw/rtl/sgb_ram.sv
hw/rtl/segment_graph_builder_top.sv
dv/graph_check_pkg.sv
dv/tb.sv
